// ----- sv/dynamo_brake_light_detector_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dynamo brake light detector
// Clocked, reset-gated implication checks used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef DYNAMO_BRAKE_LIGHT_DETECTOR_ASSERT_SVH
`define DYNAMO_BRAKE_LIGHT_DETECTOR_ASSERT_SVH

// same-cycle implication
`define DBLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbld check failed");

// next-cycle implication
`define DBLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbld check failed");

`endif

// ----- sv/dbld_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dbld_pkg
// Word types, register map, reset values and event codes of the detector.
// ----------------------------------------------------------------------------
package dbld_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] CMD_CAPTURE = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_SUPPLY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_DUTY       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_DUTY      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_POWER_DUTY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GATE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_THRESHOLD = 3'd4;

  localparam logic [7:0]  RST_BRAKE_DUTY       = 8'hff;
  localparam logic [7:0]  RST_CRUISE_DUTY      = 8'h4f;
  localparam logic [7:0]  RST_LOW_POWER_DUTY   = 8'h15;
  localparam logic [15:0] RST_SPEED_GATE       = 16'd20;
  localparam logic [7:0]  RST_SUPPLY_THRESHOLD = 8'd94;

  localparam logic [7:0]  RST_FRONT_LEVEL = 8'hff;
  localparam logic [7:0]  RST_REAR_LEVEL  = 8'h4f;
  localparam logic [15:0] COUNT_MAX       = 16'hffff;

  localparam int LIMIT_SHIFT_A = 6;
  localparam int LIMIT_SHIFT_B = 7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] capture_time;
    logic [7:0]  supply_sample;
  } in_word_t;

  typedef struct packed {
    logic [7:0] front_duty;
    logic [7:0] rear_duty;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  brake_duty;
    logic [7:0]  cruise_duty;
    logic [7:0]  low_power_duty;
    logic [15:0] speed_gate;
    logic [7:0]  supply_threshold;
  } regs_t;

  typedef struct packed {
    logic [15:0] last_capture;
    logic [15:0] last_period;
    logic [15:0] pulse_count;
    logic [15:0] last_pulse_count;
    logic [7:0]  front_level;
    logic [7:0]  rear_level;
  } state_t;

endpackage

`default_nettype wire

// ----- sv/dynamo_brake_light_detector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dynamo_brake_light_detector
// Brake detection from dynamo pulse timing; sets front and rear light duty.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction | word
//  --------+--------------------------------+-----------+--------------------
//  in      | in_valid in_ready in_data      | input     | cmd, time, sample
//  out     | out_valid out_ready out_data   | output    | front, rear duty
//  cfg     | cfg_valid cfg_ready cfg_index  | input     | register write
//          | cfg_data                       |           |
//
// One event per cycle unless a stalled result holds it back: input register,
// event logic, result register; out_valid rises when the result register loads.
// The state update and result load happen together in the event stage.
// A stalled result holds the event stage; the input register takes one more.
// Synchronous active-low reset restores register defaults and light levels.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "dynamo_brake_light_detector_assert.svh"

module dynamo_brake_light_detector (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  var dbld_pkg::in_word_t             in_data,
  output logic                               out_valid,
  input  wire                                out_ready,
  output dbld_pkg::out_word_t                out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [dbld_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [dbld_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dbld_pkg::*;

  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      out_vld_r;
  out_word_t out_word_r;
  regs_t     regs_r;
  state_t    state_r;
  state_t    state_nxt;
  logic      advance;

  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;
  assign cfg_ready = 1'b1;

  dbld_core u_core (
    .item (in_word_r),
    .regs (regs_r),
    .cur  (state_r),
    .nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r.front_duty <= state_nxt.front_level;
      out_word_r.rear_duty  <= state_nxt.rear_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.last_capture     <= 16'd0;
      state_r.last_period      <= 16'd0;
      state_r.pulse_count      <= 16'd0;
      state_r.last_pulse_count <= 16'd0;
      state_r.front_level      <= RST_FRONT_LEVEL;
      state_r.rear_level       <= RST_REAR_LEVEL;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.brake_duty       <= RST_BRAKE_DUTY;
      regs_r.cruise_duty      <= RST_CRUISE_DUTY;
      regs_r.low_power_duty   <= RST_LOW_POWER_DUTY;
      regs_r.speed_gate       <= RST_SPEED_GATE;
      regs_r.supply_threshold <= RST_SUPPLY_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BRAKE_DUTY:       regs_r.brake_duty       <= cfg_data[7:0];
        REG_CRUISE_DUTY:      regs_r.cruise_duty      <= cfg_data[7:0];
        REG_LOW_POWER_DUTY:   regs_r.low_power_duty   <= cfg_data[7:0];
        REG_SPEED_GATE:       regs_r.speed_gate       <= cfg_data[15:0];
        REG_SUPPLY_THRESHOLD: regs_r.supply_threshold <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // event stage never blocks input while the result slot is empty
  `DBLD_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_vld_r, in_ready)
  // tick clears the pulse count
  `DBLD_ASSERT_NEXT(a_tick_clears, clk, rst_n, advance && in_word_r.cmd == CMD_TICK,
                    state_r.pulse_count == 16'd0)
  // pulse count saturates
  `DBLD_ASSERT_NEXT(a_count_sat, clk, rst_n,
                    advance && in_word_r.cmd == CMD_CAPTURE &&
                    state_r.pulse_count == COUNT_MAX,
                    state_r.pulse_count == COUNT_MAX)
  // only a supply sample moves the front level
  `DBLD_ASSERT_NEXT(a_front_stable, clk, rst_n,
                    !(advance && in_word_r.cmd == CMD_SUPPLY),
                    $stable(state_r.front_level))

endmodule

`default_nettype wire

// ----- sv/dbld_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dbld_core
// Next-state logic for one event: capture, period tick or supply sample.
// ----------------------------------------------------------------------------
module dbld_core (
  input  var dbld_pkg::in_word_t item,
  input  var dbld_pkg::regs_t    regs,
  input  var dbld_pkg::state_t   cur,
  output dbld_pkg::state_t       nxt
);
  import dbld_pkg::*;

  logic [15:0] period;
  logic [17:0] limit;
  logic [16:0] count_inc;

  assign period    = item.capture_time - cur.last_capture;
  assign limit     = {2'b00, cur.last_period}
                   + {2'b00, cur.last_period >> LIMIT_SHIFT_A}
                   + {2'b00, cur.last_period >> LIMIT_SHIFT_B};
  assign count_inc = {1'b0, cur.pulse_count} + 17'd1;

  always_comb begin
    nxt = cur;
    unique case (item.cmd)
      CMD_CAPTURE: begin
        if (cur.last_pulse_count < regs.speed_gate) begin
          if ({2'b00, period} > limit) begin
            nxt.rear_level = regs.brake_duty;
          end else if (period < cur.last_period) begin
            nxt.rear_level = regs.cruise_duty;
          end
        end
        nxt.last_capture = item.capture_time;
        nxt.last_period  = period;
        if (cur.pulse_count != COUNT_MAX) begin
          nxt.pulse_count = count_inc[15:0];
        end
      end
      CMD_TICK: begin
        if (cur.pulse_count >= regs.speed_gate) begin
          if (count_inc < {1'b0, cur.last_pulse_count}) begin
            nxt.rear_level = regs.brake_duty;
          end else if (cur.pulse_count > cur.last_pulse_count) begin
            nxt.rear_level = regs.cruise_duty;
          end
        end
        nxt.last_pulse_count = cur.pulse_count;
        nxt.pulse_count      = 16'd0;
      end
      CMD_SUPPLY: begin
        if (item.supply_sample > regs.supply_threshold) begin
          nxt.front_level = regs.low_power_duty;
          nxt.rear_level  = regs.low_power_duty;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire
